@@ rtl/prhp_pkg.sv @@
package prhp_pkg;

  localparam int unsigned HASH_CHARS = 56;
  localparam logic [7:0] MAX_DOMAIN_LEN_RESET = 8'd253;
  localparam int unsigned RESULT_DEPTH = 4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] CMD_UDP_ASSOC = 8'h03;
  localparam logic [7:0] ATYP_CODE_IPV4 = 8'h01;
  localparam logic [7:0] ATYP_CODE_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_CODE_IPV6 = 8'h04;

  localparam logic [2:0] ATYPE_NONE = 3'd0;
  localparam logic [2:0] ATYPE_IPV4 = 3'd1;
  localparam logic [2:0] ATYPE_DOMAIN = 3'd3;
  localparam logic [2:0] ATYPE_IPV6 = 3'd4;

  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_HEX = 3'd2;
  localparam logic [2:0] ST_BAD_CRLF = 3'd3;
  localparam logic [2:0] ST_BAD_CMD = 3'd4;
  localparam logic [2:0] ST_BAD_TYPE = 3'd5;
  localparam logic [2:0] ST_BAD_LEN = 3'd6;

  localparam logic KIND_ADDR = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [2:0]  addr_type;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [15:0] port;
    logic [8:0]  consumed;
    logic        last_of_run;
  } result_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
           ((b >= 8'h61) && (b <= 8'h66));
  endfunction

endpackage

@@ rtl/proxy_request_header_parser.sv @@
// Parses a proxy request header one byte per input word: the hash characters, CR LF, the
// command, the address type, the optional domain length, the address, the big-endian port
// and the closing CR LF. Every address byte gives one address word and the header ends in one
// report word with the status; a byte marked last that ends no header adds an incomplete
// report. A byte is taken every cycle while the four-entry result queue has room for the two
// words one byte can cause, so input runs at one byte per cycle as long as the output side
// takes a word per cycle; the phase registers and result queue are updated at the edge where
// a byte is taken. A byte taken with first_byte_i set clears all parse state first.
module proxy_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        first_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [2:0]  status_o,
  output logic [7:0]  command_o,
  output logic [2:0]  addr_type_o,
  output logic [7:0]  addr_byte_o,
  output logic [7:0]  addr_index_o,
  output logic [15:0] port_o,
  output logic [8:0]  consumed_o,
  output logic        last_of_run_o
);
  import prhp_pkg::*;

  typedef enum logic [3:0] {
    PH_HASH  = 4'd0,
    PH_CR1   = 4'd1,
    PH_LF1   = 4'd2,
    PH_CMD   = 4'd3,
    PH_ATYPE = 4'd4,
    PH_DLEN  = 4'd5,
    PH_ADDR  = 4'd6,
    PH_PORTH = 4'd7,
    PH_PORTL = 4'd8,
    PH_CR2   = 4'd9,
    PH_LF2   = 4'd10
  } phase_e;

  localparam int unsigned PtrW = $clog2(RESULT_DEPTH);
  localparam int unsigned CntW = $clog2(RESULT_DEPTH + 1);

  logic [7:0] max_len_q;

  phase_e     phase_q, phase_d, phase_c;
  logic [7:0] field_cnt_q, field_cnt_d, field_cnt_c;
  logic [8:0] byte_total_q, byte_total_d, byte_total_c;
  logic [7:0] command_q, command_d, command_c;
  logic [2:0] atype_q, atype_d, atype_c;
  logic [7:0] dom_len_q, dom_len_d, dom_len_c;
  logic [7:0] port_hi_q, port_hi_d, port_hi_c;
  logic       finished_q, finished_d, finished_c;

  result_t        fifo_q [RESULT_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  logic      in_acc, out_acc;
  logic      has_addr, has_rep;
  logic [2:0] err, rep_status;
  logic      ok_final;
  logic [1:0] push;
  result_t   res_addr, res_rep, entry0;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    phase_c      = first_byte_i ? PH_HASH : phase_q;
    field_cnt_c  = first_byte_i ? 8'd0 : field_cnt_q;
    byte_total_c = first_byte_i ? 9'd0 : byte_total_q;
    command_c    = first_byte_i ? 8'd0 : command_q;
    atype_c      = first_byte_i ? ATYPE_NONE : atype_q;
    dom_len_c    = first_byte_i ? 8'd0 : dom_len_q;
    port_hi_c    = first_byte_i ? 8'd0 : port_hi_q;
    finished_c   = first_byte_i ? 1'b0 : finished_q;

    phase_d      = phase_c;
    field_cnt_d  = field_cnt_c;
    byte_total_d = byte_total_c;
    command_d    = command_c;
    atype_d      = atype_c;
    dom_len_d    = dom_len_c;
    port_hi_d    = port_hi_c;
    finished_d   = finished_c;
    err          = ST_OK;
    has_addr     = 1'b0;
    ok_final     = 1'b0;

    if (!finished_c) begin
      if (byte_total_c != 9'h1FF) begin
        byte_total_d = byte_total_c + 9'd1;
      end
      unique case (phase_c)
        PH_HASH: begin
          if (!is_hex(data_byte_i)) begin
            err = ST_BAD_HEX;
          end else if ({1'b0, field_cnt_c} + 9'd1 >= 9'(HASH_CHARS)) begin
            field_cnt_d = 8'd0;
            phase_d     = PH_CR1;
          end else begin
            field_cnt_d = field_cnt_c + 8'd1;
          end
        end
        PH_CR1: begin
          if (data_byte_i != CHAR_CR) err = ST_BAD_CRLF;
          else phase_d = PH_LF1;
        end
        PH_LF1: begin
          if (data_byte_i != CHAR_LF) err = ST_BAD_CRLF;
          else phase_d = PH_CMD;
        end
        PH_CMD: begin
          command_d = data_byte_i;
          if (data_byte_i != CMD_CONNECT && data_byte_i != CMD_UDP_ASSOC) err = ST_BAD_CMD;
          else phase_d = PH_ATYPE;
        end
        PH_ATYPE: begin
          if (data_byte_i == ATYP_CODE_IPV4) begin
            atype_d     = ATYPE_IPV4;
            dom_len_d   = IPV4_LEN;
            field_cnt_d = 8'd0;
            phase_d     = PH_ADDR;
          end else if (data_byte_i == ATYP_CODE_DOMAIN) begin
            atype_d = ATYPE_DOMAIN;
            phase_d = PH_DLEN;
          end else if (data_byte_i == ATYP_CODE_IPV6) begin
            atype_d     = ATYPE_IPV6;
            dom_len_d   = IPV6_LEN;
            field_cnt_d = 8'd0;
            phase_d     = PH_ADDR;
          end else begin
            err = ST_BAD_TYPE;
          end
        end
        PH_DLEN: begin
          if (data_byte_i == 8'd0 || data_byte_i > max_len_q) begin
            err = ST_BAD_LEN;
          end else begin
            dom_len_d   = data_byte_i;
            field_cnt_d = 8'd0;
            phase_d     = PH_ADDR;
          end
        end
        PH_ADDR: begin
          has_addr = 1'b1;
          if ({1'b0, field_cnt_c} + 9'd1 >= {1'b0, dom_len_c}) begin
            field_cnt_d = 8'd0;
            phase_d     = PH_PORTH;
          end else begin
            field_cnt_d = field_cnt_c + 8'd1;
          end
        end
        PH_PORTH: begin
          port_hi_d = data_byte_i;
          phase_d   = PH_PORTL;
        end
        PH_PORTL: begin
          phase_d = PH_CR2;
        end
        PH_CR2: begin
          if (data_byte_i != CHAR_CR) err = ST_BAD_CRLF;
          else phase_d = PH_LF2;
        end
        PH_LF2: begin
          if (data_byte_i != CHAR_LF) err = ST_BAD_CRLF;
          else ok_final = 1'b1;
        end
        default: begin
          phase_d = PH_HASH;
          err     = ST_BAD_HEX;
        end
      endcase
    end

    has_rep = !finished_c && ((err != ST_OK) || ok_final || last_byte_i);
    if (has_rep) begin
      finished_d = 1'b1;
    end
    priority if (err != ST_OK) begin
      rep_status = err;
    end else if (ok_final) begin
      rep_status = ST_OK;
    end else begin
      rep_status = ST_INCOMPLETE;
    end
  end

  // The low port byte is only needed by the final report, so it is kept outside the phase logic.
  logic [7:0] port_lo_q;

  always_comb begin
    res_addr             = '0;
    res_addr.result_kind = KIND_ADDR;
    res_addr.status      = ST_OK;
    res_addr.command     = command_d;
    res_addr.addr_type   = atype_d;
    res_addr.addr_byte   = data_byte_i;
    res_addr.addr_index  = field_cnt_c;
    res_addr.last_of_run = !has_rep;

    res_rep             = '0;
    res_rep.result_kind = KIND_REPORT;
    res_rep.status      = rep_status;
    res_rep.command     = command_d;
    res_rep.addr_type   = atype_d;
    res_rep.last_of_run = 1'b1;
    if (ok_final) begin
      res_rep.port     = {port_hi_c, port_lo_q};
      res_rep.consumed = byte_total_d;
    end

    entry0 = has_addr ? res_addr : res_rep;
    push   = in_acc ? ({1'b0, has_addr} + {1'b0, has_rep}) : 2'd0;
    count_d = count_q + CntW'(push) - CntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= MAX_DOMAIN_LEN_RESET;
      phase_q      <= PH_HASH;
      field_cnt_q  <= 8'd0;
      byte_total_q <= 9'd0;
      command_q    <= 8'd0;
      atype_q      <= ATYPE_NONE;
      dom_len_q    <= 8'd0;
      port_hi_q    <= 8'd0;
      port_lo_q    <= 8'd0;
      finished_q   <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q      <= phase_d;
        field_cnt_q  <= field_cnt_d;
        byte_total_q <= byte_total_d;
        command_q    <= command_d;
        atype_q      <= atype_d;
        dom_len_q    <= dom_len_d;
        port_hi_q    <= port_hi_d;
        finished_q   <= finished_d;
        if (first_byte_i) begin
          port_lo_q <= 8'd0;
        end
        if (!finished_c && phase_c == PH_PORTL) begin
          port_lo_q <= data_byte_i;
        end
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(push);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_acc);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push != 2'd0) begin
      fifo_q[wr_ptr_q] <= entry0;
    end
    if (push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res_rep;
    end
  end

  assign in_ready_o  = (count_q <= CntW'(RESULT_DEPTH - 2));
  assign out_valid_o = (count_q != '0);

  assign result_kind_o = fifo_q[rd_ptr_q].result_kind;
  assign status_o      = fifo_q[rd_ptr_q].status;
  assign command_o     = fifo_q[rd_ptr_q].command;
  assign addr_type_o   = fifo_q[rd_ptr_q].addr_type;
  assign addr_byte_o   = fifo_q[rd_ptr_q].addr_byte;
  assign addr_index_o  = fifo_q[rd_ptr_q].addr_index;
  assign port_o        = fifo_q[rd_ptr_q].port;
  assign consumed_o    = fifo_q[rd_ptr_q].consumed;
  assign last_of_run_o = fifo_q[rd_ptr_q].last_of_run;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RESULT_DEPTH))
    else $error("result queue overflow");

  a_idle_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && finished_q && !first_byte_i && !out_acc) |=> (count_q == $past(count_q)))
    else $error("byte after report produced a word");

  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i && (first_byte_i || !finished_q)) |=> finished_q)
    else $error("last byte did not end the header");

  a_domain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ADDR && !finished_q) |-> (field_cnt_q < dom_len_q))
    else $error("address index ran past the address length");

endmodule

@@ tb/tb_proxy_request_header_parser.sv @@
module tb_proxy_request_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import prhp_pkg::*;

  typedef enum logic [3:0] {
    PH_HASH, PH_CR1, PH_LF1, PH_CMD, PH_ATYPE, PH_DLEN, PH_ADDR, PH_PORTH, PH_PORTL,
    PH_CR2, PH_LF2
  } phase_e;

  localparam int POS_CR1 = HASH_CHARS;
  localparam int POS_LF1 = HASH_CHARS + 1;
  localparam int POS_CMD = HASH_CHARS + 2;
  localparam int POS_ATYPE = HASH_CHARS + 3;
  localparam int POS_ADDR = HASH_CHARS + 4;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        first_byte_i;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        result_kind_o;
  logic [2:0]  status_o;
  logic [7:0]  command_o;
  logic [2:0]  addr_type_o;
  logic [7:0]  addr_byte_o;
  logic [7:0]  addr_index_o;
  logic [15:0] port_o;
  logic [8:0]  consumed_o;
  logic        last_of_run_o;

  phase_e      phase;
  logic [7:0]  field_pos;
  logic [7:0]  cmd_seen;
  logic [2:0]  atype_seen;
  logic [7:0]  addr_len;
  logic [7:0]  port_hi;
  logic [7:0]  port_lo;
  logic [8:0]  byte_count;
  logic        hdr_done;
  logic        byte_used;
  logic [7:0]  max_len;

  result_t     expected_words [$];
  result_t     want_word;
  logic [7:0]  hdr_bytes [$];

  int errors = 0;
  int words_checked = 0;
  int reports_checked = 0;
  int bytes_parsed = 0;
  int bytes_sent = 0;
  int input_stalls = 0;
  int cfg_writes = 0;
  int hold_cycles = 0;
  int rx_stall_left = 0;
  logic tx_idle_on;
  logic rx_idle_on;

  proxy_request_header_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_byte_i  (first_byte_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .command_o     (command_o),
    .addr_type_o   (addr_type_o),
    .addr_byte_o   (addr_byte_o),
    .addr_index_o  (addr_index_o),
    .port_o        (port_o),
    .consumed_o    (consumed_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL proxy_request_header_parser");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic is_hash_char(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return (c >= 8'h30 && c <= 8'h39) || (folded >= 8'h61 && folded <= 8'h66);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 16) return 8'h41 + 8'(r - 10);
    return 8'h61 + 8'(r - 16);
  endfunction

  function automatic void clear_parse();
    phase = PH_HASH;
    field_pos = '0;
    byte_count = '0;
    cmd_seen = '0;
    atype_seen = ATYPE_NONE;
    addr_len = '0;
    port_hi = '0;
    port_lo = '0;
    hdr_done = 1'b0;
  endfunction

  function automatic result_t make_word(input logic kind, input logic [2:0] status,
                                        input logic [7:0] abyte, input logic [7:0] aindex,
                                        input logic [15:0] port, input logic [8:0] cons);
    result_t w;
    w.result_kind = kind;
    w.status = status;
    w.command = cmd_seen;
    w.addr_type = atype_seen;
    w.addr_byte = abyte;
    w.addr_index = aindex;
    w.port = port;
    w.consumed = cons;
    w.last_of_run = 1'b0;
    return w;
  endfunction

  task automatic parse_byte(input logic first, input logic [7:0] b, input logic last);
    result_t    run_words [2];
    int         n;
    logic [2:0] err;
    logic       reported;
    n = 0;
    err = ST_OK;
    reported = 1'b0;
    byte_used = 1'b0;
    if (first) clear_parse();
    if (!hdr_done) begin
      byte_used = 1'b1;
      if (byte_count < 9'd511) byte_count++;
      case (phase)
        PH_HASH: begin
          if (!is_hash_char(b)) begin
            err = ST_BAD_HEX;
          end else begin
            field_pos++;
            if (field_pos >= HASH_CHARS) begin
              field_pos = '0;
              phase = PH_CR1;
            end
          end
        end
        PH_CR1: begin
          if (b != CHAR_CR) err = ST_BAD_CRLF;
          else phase = PH_LF1;
        end
        PH_LF1: begin
          if (b != CHAR_LF) err = ST_BAD_CRLF;
          else phase = PH_CMD;
        end
        PH_CMD: begin
          cmd_seen = b;
          if (b != CMD_CONNECT && b != CMD_UDP_ASSOC) err = ST_BAD_CMD;
          else phase = PH_ATYPE;
        end
        PH_ATYPE: begin
          case (b)
            ATYP_CODE_IPV4: begin
              atype_seen = ATYPE_IPV4;
              addr_len = IPV4_LEN;
              field_pos = '0;
              phase = PH_ADDR;
            end
            ATYP_CODE_DOMAIN: begin
              atype_seen = ATYPE_DOMAIN;
              phase = PH_DLEN;
            end
            ATYP_CODE_IPV6: begin
              atype_seen = ATYPE_IPV6;
              addr_len = IPV6_LEN;
              field_pos = '0;
              phase = PH_ADDR;
            end
            default: err = ST_BAD_TYPE;
          endcase
        end
        PH_DLEN: begin
          if (b == 8'd0 || b > max_len) begin
            err = ST_BAD_LEN;
          end else begin
            addr_len = b;
            field_pos = '0;
            phase = PH_ADDR;
          end
        end
        PH_ADDR: begin
          run_words[n] = make_word(KIND_ADDR, ST_OK, b, field_pos, '0, '0);
          n++;
          field_pos++;
          if (field_pos >= addr_len) begin
            field_pos = '0;
            phase = PH_PORTH;
          end
        end
        PH_PORTH: begin
          port_hi = b;
          phase = PH_PORTL;
        end
        PH_PORTL: begin
          port_lo = b;
          phase = PH_CR2;
        end
        PH_CR2: begin
          if (b != CHAR_CR) err = ST_BAD_CRLF;
          else phase = PH_LF2;
        end
        PH_LF2: begin
          if (b != CHAR_LF) begin
            err = ST_BAD_CRLF;
          end else begin
            run_words[n] = make_word(KIND_REPORT, ST_OK, '0, '0, {port_hi, port_lo}, byte_count);
            n++;
            reported = 1'b1;
            hdr_done = 1'b1;
          end
        end
        default: begin
          phase = PH_HASH;
          err = ST_BAD_HEX;
        end
      endcase
      if (err != ST_OK) begin
        run_words[n] = make_word(KIND_REPORT, err, '0, '0, '0, '0);
        n++;
        reported = 1'b1;
        hdr_done = 1'b1;
      end
      if (!reported && last) begin
        run_words[n] = make_word(KIND_REPORT, ST_INCOMPLETE, '0, '0, '0, '0);
        n++;
        hdr_done = 1'b1;
      end
      if (n > 0) run_words[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_words.push_back(run_words[i]);
    end
  endtask

  task automatic note_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        note_mismatch("result word arrived with nothing expected");
      end else begin
        want_word = expected_words.pop_front();
        check_field("result_kind", 32'(result_kind_o), 32'(want_word.result_kind));
        check_field("status", 32'(status_o), 32'(want_word.status));
        check_field("command", 32'(command_o), 32'(want_word.command));
        check_field("addr_type", 32'(addr_type_o), 32'(want_word.addr_type));
        check_field("addr_byte", 32'(addr_byte_o), 32'(want_word.addr_byte));
        check_field("addr_index", 32'(addr_index_o), 32'(want_word.addr_index));
        check_field("port", 32'(port_o), 32'(want_word.port));
        check_field("consumed", 32'(consumed_o), 32'(want_word.consumed));
        check_field("last_of_run", 32'(last_of_run_o), 32'(want_word.last_of_run));
        words_checked++;
        if (want_word.result_kind == KIND_REPORT) reports_checked++;
      end
    end
  end

  initial begin : rx_side
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (rx_stall_left > 0) begin
        out_ready_i <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_idle_on && $urandom_range(99) < 25) rx_stall_left = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic first, input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_byte_i <= first;
    data_byte_i <= b;
    last_byte_i <= last;
    do begin
      @(posedge clk_i);
      if (!in_ready_o) input_stalls++;
    end while (!in_ready_o);
    bytes_sent++;
    parse_byte(first, b, last);
    if (byte_used) bytes_parsed++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [7:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    max_len = value;
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic build_header(input logic [7:0] cmd, input logic [7:0] atyp,
                              input logic [7:0] dlen, input logic [15:0] port);
    int n;
    hdr_bytes.delete();
    repeat (HASH_CHARS) hdr_bytes.push_back(rand_hex_char());
    hdr_bytes.push_back(CHAR_CR);
    hdr_bytes.push_back(CHAR_LF);
    hdr_bytes.push_back(cmd);
    hdr_bytes.push_back(atyp);
    if (atyp == ATYP_CODE_IPV4) begin
      n = int'(IPV4_LEN);
    end else if (atyp == ATYP_CODE_IPV6) begin
      n = int'(IPV6_LEN);
    end else begin
      n = int'(dlen);
      hdr_bytes.push_back(dlen);
    end
    repeat (n) hdr_bytes.push_back(8'($urandom));
    hdr_bytes.push_back(port[15:8]);
    hdr_bytes.push_back(port[7:0]);
    hdr_bytes.push_back(CHAR_CR);
    hdr_bytes.push_back(CHAR_LF);
  endtask

  task automatic send_header(input logic with_first, input int last_at);
    int stop;
    stop = hdr_bytes.size() - 1;
    if (last_at >= 0 && last_at < stop) stop = last_at;
    for (int i = 0; i <= stop; i++) begin
      send_byte(with_first && i == 0, hdr_bytes[i], i == last_at);
    end
  endtask

  task automatic send_with_byte(input logic [7:0] atyp, input int pos, input logic [7:0] value);
    build_header(CMD_CONNECT, atyp, 8'd5, 16'($urandom));
    if (pos < 0) pos = hdr_bytes.size() + pos;
    hdr_bytes[pos] = value;
    send_header(1'b1, pos);
  endtask

  task automatic send_domain(input logic [7:0] dlen);
    build_header(CMD_UDP_ASSOC, ATYP_CODE_DOMAIN, dlen, 16'($urandom));
    if (dlen == 8'd0 || dlen > max_len) send_header(1'b1, POS_ADDR);
    else send_header(1'b1, -1);
  endtask

  task automatic test_after_reset();
    build_header(CMD_CONNECT, ATYP_CODE_IPV4, 8'd0, 16'h1F90);
    send_header(1'b0, -1);
    send_byte(1'b0, 8'h41, 1'b1);
  endtask

  task automatic test_address_types();
    logic [7:0] hex_bounds [6];
    hex_bounds = '{8'h30, 8'h39, 8'h41, 8'h46, 8'h61, 8'h66};
    build_header(CMD_CONNECT, ATYP_CODE_IPV4, 8'd0, 16'h0000);
    hdr_bytes[POS_ADDR] = 8'h00;
    hdr_bytes[POS_ADDR + 3] = 8'hFF;
    send_header(1'b1, -1);
    build_header(CMD_CONNECT, ATYP_CODE_DOMAIN, 8'd1, 16'h0050);
    for (int i = 0; i < HASH_CHARS; i++) hdr_bytes[i] = hex_bounds[i % 6];
    send_header(1'b1, hdr_bytes.size() - 1);
  endtask

  task automatic test_bad_fields();
    logic [7:0] non_hex [6];
    non_hex = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    foreach (non_hex[i]) send_byte(1'b1, non_hex[i], 1'b0);
    send_with_byte(ATYP_CODE_IPV4, POS_CR1, CHAR_LF);
    send_with_byte(ATYP_CODE_IPV4, POS_LF1, CHAR_CR);
    send_with_byte(ATYP_CODE_IPV4, POS_CMD, 8'h02);
    send_with_byte(ATYP_CODE_IPV4, POS_ATYPE, 8'h02);
    send_with_byte(ATYP_CODE_DOMAIN, POS_ADDR, 8'd0);
    send_with_byte(ATYP_CODE_DOMAIN, POS_ADDR, MAX_DOMAIN_LEN_RESET + 8'd1);
    send_with_byte(ATYP_CODE_IPV6, -2, CHAR_LF);
    send_with_byte(ATYP_CODE_IPV4, -1, CHAR_CR);
  endtask

  task automatic test_early_end();
    send_byte(1'b1, rand_hex_char(), 1'b1);
    build_header(CMD_CONNECT, ATYP_CODE_IPV4, 8'd0, 16'($urandom));
    send_header(1'b1, 10);
    send_header(1'b1, POS_CR1);
    send_header(1'b1, POS_ADDR + 1);
    build_header(CMD_CONNECT, ATYP_CODE_DOMAIN, 8'd3, 16'($urandom));
    send_header(1'b1, POS_ADDR);
    hdr_bytes[POS_CMD] = 8'h07;
    send_header(1'b1, POS_CMD);
    send_byte(1'b0, CHAR_CR, 1'b1);
    send_byte(1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_restart();
    build_header(CMD_UDP_ASSOC, ATYP_CODE_IPV6, 8'd0, 16'($urandom));
    for (int i = 0; i < POS_ADDR + 6; i++) send_byte(i == 0, hdr_bytes[i], 1'b0);
    build_header(CMD_CONNECT, ATYP_CODE_IPV4, 8'd0, 16'($urandom));
    send_header(1'b1, -1);
  endtask

  task automatic test_config_extremes();
    write_max_len(8'd1);
    send_domain(8'd1);
    send_domain(8'd2);
    write_max_len(8'd255);
    send_domain(8'd255);
    write_max_len(8'd0);
    send_domain(8'd1);
    write_max_len(MAX_DOMAIN_LEN_RESET);
    send_domain(MAX_DOMAIN_LEN_RESET + 8'd1);
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    wait_drained();
    hold_cycles = 200;
    build_header(CMD_CONNECT, ATYP_CODE_IPV6, 8'd0, 16'($urandom));
    send_header(1'b1, -1);
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int start, hdr_count, r, lim, pos, last_at;
    logic [7:0] cmd, atyp, dlen, cfg_pick, nasty;
    start = bytes_sent;
    hdr_count = 0;
    while (bytes_sent - start < 250) begin
      if (hdr_count % 6 == 5) begin
        case ($urandom_range(3))
          0: cfg_pick = 8'd1;
          1: cfg_pick = 8'd255;
          2: cfg_pick = MAX_DOMAIN_LEN_RESET;
          default: cfg_pick = 8'($urandom_range(255, 1));
        endcase
        write_max_len(cfg_pick);
      end
      tx_idle_on = ($urandom_range(4) != 0);
      rx_idle_on = ($urandom_range(4) != 0);
      cmd = $urandom_range(1) ? CMD_CONNECT : CMD_UDP_ASSOC;
      r = $urandom_range(99);
      atyp = (r < 35) ? ATYP_CODE_IPV4 : (r < 60) ? ATYP_CODE_IPV6 : ATYP_CODE_DOMAIN;
      lim = (max_len == 8'd0) ? 1 : int'(max_len);
      r = $urandom_range(99);
      if (r < 80) dlen = 8'($urandom_range((lim < 12) ? lim : 12, 1));
      else if (r < 95) dlen = 8'($urandom_range(lim, 1));
      else dlen = 8'(lim);
      build_header(cmd, atyp, dlen, 16'($urandom));
      r = $urandom_range(99);
      if (r < 50) begin
        last_at = -1;
        if ($urandom_range(5) == 0) last_at = $urandom_range(hdr_bytes.size() - 1);
        send_header(1'b1, last_at);
      end else if (r < 80) begin
        if ($urandom_range(1) == 0) pos = $urandom_range(hdr_bytes.size() - 1, POS_CR1);
        else pos = $urandom_range(hdr_bytes.size() - 1);
        case ($urandom_range(11))
          0: nasty = CHAR_CR;
          1: nasty = CHAR_LF;
          2: nasty = CMD_CONNECT;
          3: nasty = CMD_UDP_ASSOC;
          4: nasty = ATYP_CODE_IPV6;
          5: nasty = 8'h00;
          default: nasty = 8'($urandom);
        endcase
        hdr_bytes[pos] = nasty;
        send_header(1'b1, -1);
      end else if (r < 92) begin
        repeat ($urandom_range(8, 1)) begin
          send_byte(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
        end
      end else begin
        send_header(1'b0, -1);
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) send_byte(1'b0, 8'($urandom), 1'($urandom_range(1)));
      end
      hdr_count++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    first_byte_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    max_len = MAX_DOMAIN_LEN_RESET;
    clear_parse();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_address_types();
    test_bad_fields();
    test_early_end();
    test_restart();
    test_config_extremes();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_words.size() != 0) note_mismatch("expected words never arrived");
    $display("Sent %0d bytes, %0d of them parsed, giving %0d result words, %0d of them reports.",
             bytes_sent, bytes_parsed, words_checked, reports_checked);
    $display("Register writes: %0d; cycles the input was held off: %0d; mismatches: %0d.",
             cfg_writes, input_stalls, errors);
    if (errors == 0) begin
      $display("PASS proxy_request_header_parser");
    end else begin
      $display("FAIL proxy_request_header_parser");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/prhp_pkg.sv
rtl/proxy_request_header_parser.sv
tb/tb_proxy_request_header_parser.sv
